FILE: rtl/greedy_nearest_path_order_unit_macros.svh
// Assertion macros for the greedy nearest path order unit.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef GREEDY_NEAREST_PATH_ORDER_UNIT_MACROS_SVH
`define GREEDY_NEAREST_PATH_ORDER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define GNPO_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define GNPO_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/gnpo_pkg.sv
// Shared types for the greedy nearest path order unit.
// No dependencies; used by the cell and the top level.
package gnpo_pkg;

	// Width of the emitted path number
	localparam int unsigned NUM_BITS = 6;

	// Sequencer states, one-hot
	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_FLUSH1 = 5'b00100,
		ST_FLUSH2 = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	// Control broadcast to every cell of the ring
	typedef struct packed {
		logic shift;  // take the neighbor's contents
		logic clear;  // drop valid and used marks
		logic mark;   // set used on the cell whose index matches
	} cell_ctrl_t;

endpackage

FILE: rtl/gnpo_cell.sv
// One cell of the path ring: holds one stored path with its index and marks.
// Depends on gnpo_pkg for the control struct.
module gnpo_cell #(
	parameter int unsigned COORD_BITS = 20,
	parameter int unsigned IDX_BITS   = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gnpo_pkg::cell_ctrl_t         ctrl,
	input  logic [IDX_BITS-1:0]          mark_idx,
	input  logic                         in_valid,
	input  logic                         in_used,
	input  logic [IDX_BITS-1:0]          in_idx,
	input  logic signed [COORD_BITS-1:0] in_sx,
	input  logic signed [COORD_BITS-1:0] in_sy,
	input  logic signed [COORD_BITS-1:0] in_ex,
	input  logic signed [COORD_BITS-1:0] in_ey,
	output logic                         valid,
	output logic                         used,
	output logic [IDX_BITS-1:0]          idx,
	output logic signed [COORD_BITS-1:0] sx,
	output logic signed [COORD_BITS-1:0] sy,
	output logic signed [COORD_BITS-1:0] ex,
	output logic signed [COORD_BITS-1:0] ey
);

	logic                         valid_q;
	logic                         used_q;
	logic [IDX_BITS-1:0]          idx_q;
	logic signed [COORD_BITS-1:0] sx_q;
	logic signed [COORD_BITS-1:0] sy_q;
	logic signed [COORD_BITS-1:0] ex_q;
	logic signed [COORD_BITS-1:0] ey_q;

	// Marks: clear, shift along with the data, or set used on a match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			used_q  <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
			used_q  <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= in_valid;
			used_q  <= in_used;
		end else if (ctrl.mark && valid_q && (idx_q == mark_idx)) begin
			used_q <= 1'b1;
		end
	end

	// Payload: advance with the ring
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			idx_q <= in_idx;
			sx_q  <= in_sx;
			sy_q  <= in_sy;
			ex_q  <= in_ex;
			ey_q  <= in_ey;
		end
	end

	assign valid = valid_q;
	assign used  = used_q;
	assign idx   = idx_q;
	assign sx    = sx_q;
	assign sy    = sy_q;
	assign ex    = ex_q;
	assign ey    = ey_q;

endmodule

FILE: rtl/gnpo_dist.sv
// Distance and best-candidate unit: squared distance in difference and
// square stages, keeps the nearest unused start of the current pass. No package use.
module gnpo_dist #(
	parameter int unsigned COORD_BITS = 20,
	parameter int unsigned IDX_BITS   = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         restart,
	input  logic                         feed,
	input  logic signed [COORD_BITS-1:0] qx,
	input  logic signed [COORD_BITS-1:0] qy,
	input  logic [IDX_BITS-1:0]          cand_idx,
	input  logic signed [COORD_BITS-1:0] cand_sx,
	input  logic signed [COORD_BITS-1:0] cand_sy,
	input  logic signed [COORD_BITS-1:0] cand_ex,
	input  logic signed [COORD_BITS-1:0] cand_ey,
	output logic                         found,
	output logic [IDX_BITS-1:0]          best_idx,
	output logic signed [COORD_BITS-1:0] best_ex,
	output logic signed [COORD_BITS-1:0] best_ey
);

	localparam int unsigned DIFF_BITS = COORD_BITS + 1;
	localparam int unsigned PROD_BITS = 2 * DIFF_BITS;
	localparam int unsigned SQ_BITS   = 2 * COORD_BITS + 1;
	localparam int unsigned DIST_BITS = SQ_BITS + 1;

	// Stage 1: differences
	logic                         v_s1;
	logic signed [DIFF_BITS-1:0]  dx_s1;
	logic signed [DIFF_BITS-1:0]  dy_s1;
	logic [IDX_BITS-1:0]          idx_s1;
	logic signed [COORD_BITS-1:0] ex_s1;
	logic signed [COORD_BITS-1:0] ey_s1;

	// Stage 2: squares
	logic                         v_s2;
	logic [SQ_BITS-1:0]           sqx_s2;
	logic [SQ_BITS-1:0]           sqy_s2;
	logic [IDX_BITS-1:0]          idx_s2;
	logic signed [COORD_BITS-1:0] ex_s2;
	logic signed [COORD_BITS-1:0] ey_s2;

	// Best so far
	logic                         found_q;
	logic [DIST_BITS-1:0]         best_d_q;
	logic [IDX_BITS-1:0]          best_idx_q;
	logic signed [COORD_BITS-1:0] best_ex_q;
	logic signed [COORD_BITS-1:0] best_ey_q;

	logic signed [PROD_BITS-1:0]  prod_x;
	logic signed [PROD_BITS-1:0]  prod_y;
	logic [DIST_BITS-1:0]         dist_sum;
	logic                         take;

	assign prod_x   = dx_s1 * dx_s1;
	assign prod_y   = dy_s1 * dy_s1;
	assign dist_sum = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	// Replace on strictly nearer, or equal distance with a lower index
	assign take = v_s2 && (!found_q || (dist_sum < best_d_q) ||
		((dist_sum == best_d_q) && (idx_s2 < best_idx_q)));

	// Advance valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= feed;
			v_s2 <= v_s1;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		dx_s1  <= DIFF_BITS'(cand_sx) - DIFF_BITS'(qx);
		dy_s1  <= DIFF_BITS'(cand_sy) - DIFF_BITS'(qy);
		idx_s1 <= cand_idx;
		ex_s1  <= cand_ex;
		ey_s1  <= cand_ey;
		sqx_s2 <= prod_x[SQ_BITS-1:0];
		sqy_s2 <= prod_y[SQ_BITS-1:0];
		idx_s2 <= idx_s1;
		ex_s2  <= ex_s1;
		ey_s2  <= ey_s1;
	end

	// Hold the nearest candidate of the pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (restart) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_d_q   <= dist_sum;
			best_idx_q <= idx_s2;
			best_ex_q  <= ex_s2;
			best_ey_q  <= ey_s2;
		end
	end

	assign found    = found_q;
	assign best_idx = best_idx_q;
	assign best_ex  = best_ex_q;
	assign best_ey  = best_ey_q;

endmodule

FILE: rtl/greedy_nearest_path_order_unit.sv
// Top level of the greedy nearest path order unit: ring of path cells,
// distance unit and sequencer. Depends on gnpo_pkg, gnpo_cell, gnpo_dist.
//
// Channel   Direction  Handshake                 Payload
// input     in         start & !busy             start_x start_y end_x end_y final_path
// result    out        result_valid, one cycle   path_number last_result
//
// Loading accepts one path per cycle while busy is low. A final-marked path starts
// the ordering; each emitted index then takes one full rotation of the cell ring
// past the single distance unit, a drain of its pipeline (FLUSH1, FLUSH2) and the
// presenting of the result (EMIT). busy stays high until the last index is out.
// arst_n clears all marks, the count and the minimum corner. The receiver
// cannot stall; results leave as soon as they are found.
`include "greedy_nearest_path_order_unit_macros.svh"

module greedy_nearest_path_order_unit #(
	parameter int unsigned MAX_PATHS  = 64,
	parameter int unsigned COORD_BITS = 20
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [COORD_BITS-1:0]     start_x,
	input  logic signed [COORD_BITS-1:0]     start_y,
	input  logic signed [COORD_BITS-1:0]     end_x,
	input  logic signed [COORD_BITS-1:0]     end_y,
	input  logic                             final_path,
	output logic                             result_valid,
	output logic [gnpo_pkg::NUM_BITS-1:0]    path_number,
	output logic                             last_result
);

	localparam int unsigned IDX_BITS = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
	localparam int unsigned CNT_BITS = $clog2(MAX_PATHS + 1);
	localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

	gnpo_pkg::state_t     state_q;
	gnpo_pkg::cell_ctrl_t ctrl;

	logic [CNT_BITS-1:0]          count_q;
	logic [CNT_BITS-1:0]          remain_q;
	logic [IDX_BITS-1:0]          scan_cnt_q;
	logic signed [COORD_BITS-1:0] min_x_q;
	logic signed [COORD_BITS-1:0] min_y_q;
	logic signed [COORD_BITS-1:0] min_x_nxt;
	logic signed [COORD_BITS-1:0] min_y_nxt;
	logic signed [COORD_BITS-1:0] qx_q;
	logic signed [COORD_BITS-1:0] qy_q;

	logic accept;
	logic store;
	logic full;
	logic emit_last;
	logic restart;
	logic feed;

	// Ring contents
	logic                         c_valid [MAX_PATHS];
	logic                         c_used  [MAX_PATHS];
	logic [IDX_BITS-1:0]          c_idx   [MAX_PATHS];
	logic signed [COORD_BITS-1:0] c_sx    [MAX_PATHS];
	logic signed [COORD_BITS-1:0] c_sy    [MAX_PATHS];
	logic signed [COORD_BITS-1:0] c_ex    [MAX_PATHS];
	logic signed [COORD_BITS-1:0] c_ey    [MAX_PATHS];

	// Ring entry point: new path on load, head wraps around during a scan
	logic                         r_valid;
	logic                         r_used;
	logic [IDX_BITS-1:0]          r_idx;
	logic signed [COORD_BITS-1:0] r_sx;
	logic signed [COORD_BITS-1:0] r_sy;
	logic signed [COORD_BITS-1:0] r_ex;
	logic signed [COORD_BITS-1:0] r_ey;

	logic                         found;
	logic [IDX_BITS-1:0]          best_idx;
	logic signed [COORD_BITS-1:0] best_ex;
	logic signed [COORD_BITS-1:0] best_ey;

	assign busy      = (state_q != gnpo_pkg::ST_IDLE);
	assign accept    = start && !busy;
	assign full      = (count_q == CNT_BITS'(MAX_PATHS));
	assign store     = accept && !full;
	assign emit_last = (state_q == gnpo_pkg::ST_EMIT) && (remain_q == CNT_BITS'(1));
	assign restart   = (accept && final_path) ||
		((state_q == gnpo_pkg::ST_EMIT) && !emit_last);

	assign min_x_nxt = (start_x < min_x_q) ? start_x : min_x_q;
	assign min_y_nxt = (start_y < min_y_q) ? start_y : min_y_q;

	// Select what enters cell zero
	always_comb begin
		if (state_q == gnpo_pkg::ST_SCAN) begin
			r_valid = c_valid[MAX_PATHS-1];
			r_used  = c_used[MAX_PATHS-1];
			r_idx   = c_idx[MAX_PATHS-1];
			r_sx    = c_sx[MAX_PATHS-1];
			r_sy    = c_sy[MAX_PATHS-1];
			r_ex    = c_ex[MAX_PATHS-1];
			r_ey    = c_ey[MAX_PATHS-1];
		end else begin
			r_valid = 1'b1;
			r_used  = 1'b0;
			r_idx   = count_q[IDX_BITS-1:0];
			r_sx    = start_x;
			r_sy    = start_y;
			r_ex    = end_x;
			r_ey    = end_y;
		end
	end

	// Broadcast ring control
	always_comb begin
		ctrl.shift = store || (state_q == gnpo_pkg::ST_SCAN);
		ctrl.clear = emit_last;
		ctrl.mark  = (state_q == gnpo_pkg::ST_EMIT);
	end

	// Feed the head cell to the distance unit when it holds an unused path
	assign feed = (state_q == gnpo_pkg::ST_SCAN) && c_valid[MAX_PATHS-1] &&
		!c_used[MAX_PATHS-1];

	for (genvar i = 0; i < MAX_PATHS; i++) begin : g_cell
		if (i == 0) begin : g_first
			gnpo_cell #(
				.COORD_BITS(COORD_BITS),
				.IDX_BITS  (IDX_BITS)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (ctrl),
				.mark_idx(best_idx),
				.in_valid(r_valid),
				.in_used (r_used),
				.in_idx  (r_idx),
				.in_sx   (r_sx),
				.in_sy   (r_sy),
				.in_ex   (r_ex),
				.in_ey   (r_ey),
				.valid   (c_valid[i]),
				.used    (c_used[i]),
				.idx     (c_idx[i]),
				.sx      (c_sx[i]),
				.sy      (c_sy[i]),
				.ex      (c_ex[i]),
				.ey      (c_ey[i])
			);
		end else begin : g_next
			gnpo_cell #(
				.COORD_BITS(COORD_BITS),
				.IDX_BITS  (IDX_BITS)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (ctrl),
				.mark_idx(best_idx),
				.in_valid(c_valid[i-1]),
				.in_used (c_used[i-1]),
				.in_idx  (c_idx[i-1]),
				.in_sx   (c_sx[i-1]),
				.in_sy   (c_sy[i-1]),
				.in_ex   (c_ex[i-1]),
				.in_ey   (c_ey[i-1]),
				.valid   (c_valid[i]),
				.used    (c_used[i]),
				.idx     (c_idx[i]),
				.sx      (c_sx[i]),
				.sy      (c_sy[i]),
				.ex      (c_ex[i]),
				.ey      (c_ey[i])
			);
		end
	end

	gnpo_dist #(
		.COORD_BITS(COORD_BITS),
		.IDX_BITS  (IDX_BITS)
	) u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.feed    (feed),
		.qx      (qx_q),
		.qy      (qy_q),
		.cand_idx(c_idx[MAX_PATHS-1]),
		.cand_sx (c_sx[MAX_PATHS-1]),
		.cand_sy (c_sy[MAX_PATHS-1]),
		.cand_ex (c_ex[MAX_PATHS-1]),
		.cand_ey (c_ey[MAX_PATHS-1]),
		.found   (found),
		.best_idx(best_idx),
		.best_ex (best_ex),
		.best_ey (best_ey)
	);

	// Sequencer: load, rotate, drain, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= gnpo_pkg::ST_IDLE;
			count_q    <= '0;
			remain_q   <= '0;
			scan_cnt_q <= '0;
			min_x_q    <= COORD_MAX;
			min_y_q    <= COORD_MAX;
		end else begin
			case (state_q)
				gnpo_pkg::ST_IDLE: begin
					if (store) begin
						count_q <= count_q + CNT_BITS'(1);
						min_x_q <= min_x_nxt;
						min_y_q <= min_y_nxt;
					end
					if (accept && final_path) begin
						remain_q   <= store ? count_q + CNT_BITS'(1) : count_q;
						scan_cnt_q <= '0;
						state_q    <= gnpo_pkg::ST_SCAN;
					end
				end
				gnpo_pkg::ST_SCAN: begin
					scan_cnt_q <= scan_cnt_q + IDX_BITS'(1);
					if (scan_cnt_q == IDX_BITS'(MAX_PATHS - 1)) begin
						state_q <= gnpo_pkg::ST_FLUSH1;
					end
				end
				gnpo_pkg::ST_FLUSH1: begin
					state_q <= gnpo_pkg::ST_FLUSH2;
				end
				gnpo_pkg::ST_FLUSH2: begin
					state_q <= gnpo_pkg::ST_EMIT;
				end
				gnpo_pkg::ST_EMIT: begin
					remain_q   <= remain_q - CNT_BITS'(1);
					scan_cnt_q <= '0;
					if (emit_last) begin
						count_q <= '0;
						min_x_q <= COORD_MAX;
						min_y_q <= COORD_MAX;
						state_q <= gnpo_pkg::ST_IDLE;
					end else begin
						state_q <= gnpo_pkg::ST_SCAN;
					end
				end
				default: begin
					state_q <= gnpo_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Query point: minimum corner first, then the end of each chosen path
	always_ff @(posedge clk) begin
		if (accept && final_path) begin
			qx_q <= store ? min_x_nxt : min_x_q;
			qy_q <= store ? min_y_nxt : min_y_q;
		end else if (state_q == gnpo_pkg::ST_EMIT) begin
			qx_q <= best_ex;
			qy_q <= best_ey;
		end
	end

	assign result_valid = (state_q == gnpo_pkg::ST_EMIT);
	assign path_number  = gnpo_pkg::NUM_BITS'(best_idx);
	assign last_result  = emit_last;

	// Checks on sequencing
	`GNPO_ASSERT_SAME(a_emit_has_winner, result_valid, found, "result without a candidate")
	`GNPO_ASSERT_NEXT(a_no_back_to_back, result_valid, !result_valid, "results back to back")
	`GNPO_ASSERT_NEXT(a_last_frees, result_valid && last_result, !busy, "busy after last result")
	`GNPO_ASSERT_NEXT(a_final_starts, start && !busy && final_path, busy, "final path did not start")

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for greedy_nearest_path_order_unit: a path queue feeds
// the driver, and an in-bench ordering predictor checks every emitted path index.
// Depends on gnpo_pkg and the greedy_nearest_path_order_unit RTL.
module tb_top;

	localparam int unsigned MAX_PATHS  = 64;
	localparam int unsigned CW         = 20;
	localparam int unsigned QUIET_LIMIT = 4000;

	localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

	typedef enum int unsigned {
		SPREAD_FULL,
		SPREAD_TIGHT,
		SPREAD_NEAR,
		SPREAD_EDGE
	} coord_spread_t;

	typedef struct {
		logic signed [CW-1:0] sx;
		logic signed [CW-1:0] sy;
		logic signed [CW-1:0] ex;
		logic signed [CW-1:0] ey;
		logic                 fin;
	} path_item_t;

	typedef struct {
		logic [gnpo_pkg::NUM_BITS-1:0] num;
		logic                          last;
	} order_entry_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	logic signed [CW-1:0]          start_x = '0;
	logic signed [CW-1:0]          start_y = '0;
	logic signed [CW-1:0]          end_x = '0;
	logic signed [CW-1:0]          end_y = '0;
	logic                          final_path = 1'b0;
	logic                          result_valid;
	logic [gnpo_pkg::NUM_BITS-1:0] path_number;
	logic                          last_result;

	path_item_t   pending_paths[$];
	order_entry_t expected_order[$];

	// Predictor copy of the path store
	logic signed [CW-1:0] store_sx [MAX_PATHS];
	logic signed [CW-1:0] store_sy [MAX_PATHS];
	logic signed [CW-1:0] store_ex [MAX_PATHS];
	logic signed [CW-1:0] store_ey [MAX_PATHS];
	logic                 drawn    [MAX_PATHS];
	int unsigned          stored_count = 0;
	logic signed [CW-1:0] corner_x = COORD_MAX;
	logic signed [CW-1:0] corner_y = COORD_MAX;

	int unsigned paths_taken = 0;
	int unsigned quiet_cycles = 0;
	int unsigned errors = 0;
	logic        took_path = 1'b0;

	greedy_nearest_path_order_unit #(
		.MAX_PATHS (MAX_PATHS),
		.COORD_BITS(CW)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.final_path  (final_path),
		.result_valid(result_valid),
		.path_number (path_number),
		.last_result (last_result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch @%0t: %s", $time, what);
		errors++;
	endtask

	function automatic longint unsigned span_sq(input logic signed [CW-1:0] ax,
			input logic signed [CW-1:0] ay, input logic signed [CW-1:0] bx,
			input logic signed [CW-1:0] by);
		longint dx;
		longint dy;
		dx = longint'(ax) - longint'(bx);
		dy = longint'(ay) - longint'(by);
		return longint'(dx * dx + dy * dy);
	endfunction

	// Scan all undrawn paths; lowest index wins a tie
	function automatic int unsigned nearest_undrawn(input logic signed [CW-1:0] px,
			input logic signed [CW-1:0] py);
		int unsigned       best;
		longint unsigned   best_d;
		longint unsigned   d;
		bit                found;
		best = 0;
		best_d = 0;
		found = 0;
		for (int unsigned i = 0; i < stored_count; i++) begin
			if (!drawn[i]) begin
				d = span_sq(px, py, store_sx[i], store_sy[i]);
				if (!found || d < best_d) begin
					found = 1;
					best = i;
					best_d = d;
				end
			end
		end
		return best;
	endfunction

	// Store one accepted path; on the final mark, predict the whole drawing order
	task automatic absorb_path(input path_item_t p);
		int unsigned  cur;
		int unsigned  n;
		order_entry_t e;
		if (stored_count < MAX_PATHS) begin
			store_sx[stored_count] = p.sx;
			store_sy[stored_count] = p.sy;
			store_ex[stored_count] = p.ex;
			store_ey[stored_count] = p.ey;
			drawn[stored_count] = 1'b0;
			if (p.sx < corner_x) corner_x = p.sx;
			if (p.sy < corner_y) corner_y = p.sy;
			stored_count++;
		end
		if (!p.fin) return;
		n = stored_count;
		cur = nearest_undrawn(corner_x, corner_y);
		for (int unsigned k = 0; k < n; k++) begin
			if (k > 0) cur = nearest_undrawn(store_ex[cur], store_ey[cur]);
			drawn[cur] = 1'b1;
			e.num = cur[gnpo_pkg::NUM_BITS-1:0];
			e.last = (k + 1 == n);
			expected_order.insert(expected_order.size(), e);
		end
		// Start a fresh set
		stored_count = 0;
		corner_x = COORD_MAX;
		corner_y = COORD_MAX;
	endtask

	function automatic int unsigned sender_idle_pct(input int unsigned n);
		if (n < 40) return 0;
		if (n < 80) return 84;
		if (n < 100) return 34;
		return 0;
	endfunction

	function automatic logic signed [CW-1:0] pick_coord(input coord_spread_t spread);
		int c;
		case (spread)
			SPREAD_TIGHT: c = int'($urandom_range(8)) - 4;
			SPREAD_NEAR:  c = int'($urandom_range(256)) - 128;
			SPREAD_EDGE: begin
				case ($urandom_range(3))
					0: return COORD_MIN;
					1: return COORD_MAX;
					2: c = 0;
					default: c = -1;
				endcase
			end
			default: c = int'($urandom);
		endcase
		return c[CW-1:0];
	endfunction

	task automatic queue_path(input logic signed [CW-1:0] sx, input logic signed [CW-1:0] sy,
			input logic signed [CW-1:0] ex, input logic signed [CW-1:0] ey, input logic fin);
		path_item_t p;
		p.sx = sx;
		p.sy = sy;
		p.ex = ex;
		p.ey = ey;
		p.fin = fin;
		pending_paths.insert(pending_paths.size(), p);
	endtask

	// One set of paths with random content; final mark on the last one only
	task automatic queue_random_set(input int unsigned n);
		coord_spread_t spread;
		coord_spread_t s;
		spread = coord_spread_t'($urandom_range(3));
		for (int unsigned i = 0; i < n; i++) begin
			s = ($urandom_range(3) == 0) ? SPREAD_FULL : spread;
			queue_path(pick_coord(s), pick_coord(s), pick_coord(s), pick_coord(s),
				i + 1 == n);
		end
	endtask

	// Drive a transaction at the falling edge; hold it until it is accepted
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !took_path) begin
		end else if (pending_paths.size() != 0 &&
				$urandom_range(99) >= sender_idle_pct(paths_taken)) begin
			start <= 1'b1;
			start_x <= pending_paths[0].sx;
			start_y <= pending_paths[0].sy;
			end_x <= pending_paths[0].ex;
			end_y <= pending_paths[0].ey;
			final_path <= pending_paths[0].fin;
		end else begin
			start <= 1'b0;
		end
	end

	// Sample accepted paths and results; check against the predicted order
	always @(posedge clk) begin
		path_item_t   p;
		order_entry_t e;
		took_path <= arst_n && start && !busy;
		if (arst_n) begin
			if (start && !busy) begin
				p.sx = start_x;
				p.sy = start_y;
				p.ex = end_x;
				p.ey = end_y;
				p.fin = final_path;
				absorb_path(p);
				void'(pending_paths.pop_front());
				paths_taken++;
			end
			if (result_valid) begin
				if (expected_order.size() == 0) begin
					report_mismatch($sformatf("unexpected result path_number=%0d", path_number));
				end else begin
					e = expected_order.pop_front();
					if (path_number !== e.num)
						report_mismatch($sformatf("path_number %0d, predicted %0d",
							path_number, e.num));
					if (last_result !== e.last)
						report_mismatch($sformatf("last_result %0b, predicted %0b",
							last_result, e.last));
				end
			end
			// Watchdog on cycles with no transaction
			if ((start && !busy) || result_valid) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("status: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned random_items;
		bit          overflow_done;
		int unsigned n;

		// Lone path at the coordinate extremes
		queue_path(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1);
		// Identical starts: lower index first
		queue_path(CW'(0), CW'(0), CW'(16), CW'(16), 1'b0);
		queue_path(CW'(0), CW'(0), CW'(-16), CW'(-16), 1'b1);
		// Equal distances from different starts
		queue_path(CW'(10), CW'(0), CW'(0), CW'(0), 1'b0);
		queue_path(CW'(0), CW'(10), CW'(0), CW'(0), 1'b0);
		queue_path(CW'(-10), CW'(0), CW'(5), CW'(5), 1'b0);
		queue_path(CW'(0), CW'(-10), COORD_MAX, COORD_MIN, 1'b1);
		// Largest spans
		queue_path(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1'b0);
		queue_path(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b0);
		queue_path(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 1'b1);
		// Alternating bit patterns
		queue_path(20'h55555, 20'hAAAAA, 20'hAAAAA, 20'h55555, 1'b0);
		queue_path(20'hAAAAA, 20'h55555, 20'h55555, 20'hAAAAA, 1'b0);
		queue_path(CW'(-1), CW'(-1), CW'(0), CW'(0), 1'b1);

		// Random sets, mostly small; one overflows the store and ends on a dropped path
		random_items = 0;
		overflow_done = 0;
		while (random_items < 97) begin
			if (!overflow_done && random_items >= 20) begin
				queue_random_set(MAX_PATHS + 2);
				random_items += MAX_PATHS + 2;
				overflow_done = 1;
			end else begin
				n = $urandom_range(1, 8);
				queue_random_set(n);
				random_items += n;
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_paths.size() != 0 || expected_order.size() != 0) @(negedge clk);
		repeat (MAX_PATHS + 8) @(negedge clk);

		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/gnpo_pkg.sv
rtl/gnpo_cell.sv
rtl/gnpo_dist.sv
rtl/greedy_nearest_path_order_unit.sv
sim/tb_top.sv
